// ----- sv/nabd_pkg.sv -----
package nabd_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_OUT_WIDTH    = 2'd0,
		CFG_OUT_HEIGHT   = 2'd1,
		CFG_NEAREST_MODE = 2'd2,
		CFG_NULL_VALUE   = 2'd3
	} cfg_index_t;

	// register field widths
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned OUT_WIDTH_W = 9;
	localparam int unsigned HEIGHT_W    = 16;
	localparam int unsigned ROW_W       = 17;

	// register reset values
	localparam logic [OUT_WIDTH_W-1:0] OUT_WIDTH_RST  = 9'd64;
	localparam logic [HEIGHT_W-1:0]    OUT_HEIGHT_RST = 16'd64;

endpackage

// ----- sv/null_aware_box_decimator_top.sv -----
// channel   | handshake           | payload
// ----------+---------------------+----------------------------------------
// input     | in_valid / in_ready | left_pixel, right_pixel, restart
// output    | out_valid/out_ready | out_pixel, end_of_line, last
// config    | cfg_we (no wait)    | cfg_index, cfg_data
//
// One request is taken per cycle while in_ready is high. An odd-line request
// passes the line store read, null count and sum, divide-by-three multiply
// and output register in turn; even-line requests only write the line store.
// Each stage stalls only when the stage after it is full and held, so input
// keeps flowing into empty stages while a result waits on the output.
// arst_n clears the counters, valid bits and configuration registers; the
// line store is not cleared and needs no clearing pass.
module null_aware_box_decimator_top #(
	parameter int unsigned MAX_OUT_WIDTH = 256,
	parameter int unsigned PIXEL_BITS    = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [PIXEL_BITS-1:0]              left_pixel,
	input  logic [PIXEL_BITS-1:0]              right_pixel,
	input  logic                               restart,
	// output channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [PIXEL_BITS-1:0]              out_pixel,
	output logic                               end_of_line,
	output logic                               last,
	// configuration
	input  logic                               cfg_we,
	input  nabd_pkg::cfg_index_t               cfg_index,
	input  logic [nabd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int unsigned PW     = PIXEL_BITS;
	localparam int unsigned COL_W  = $clog2(MAX_OUT_WIDTH);
	localparam int unsigned WW_MIN = $clog2(MAX_OUT_WIDTH + 1);
	localparam int unsigned EW     = (WW_MIN > nabd_pkg::OUT_WIDTH_W) ?
		WW_MIN : nabd_pkg::OUT_WIDTH_W;
	localparam int unsigned SW     = PW + 2;
	localparam int unsigned K      = SW + 1;
	localparam longint unsigned RECIP_L = ((64'd1 << K) + 64'd2) / 64'd3;
	localparam logic [SW-1:0] RECIP = SW'(RECIP_L);
	localparam logic [EW-1:0] MAX_W = EW'(MAX_OUT_WIDTH);
	localparam int unsigned HW     = nabd_pkg::HEIGHT_W;
	localparam int unsigned RW     = nabd_pkg::ROW_W;

	// configuration registers
	logic [nabd_pkg::OUT_WIDTH_W-1:0] out_width_q;
	logic [HW-1:0]                    out_height_q;
	logic                             nearest_q;
	logic [nabd_pkg::CFG_DATA_W-1:0]  null_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_width_q  <= nabd_pkg::OUT_WIDTH_RST;
			out_height_q <= nabd_pkg::OUT_HEIGHT_RST;
			nearest_q    <= 1'b0;
			null_value_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nabd_pkg::CFG_OUT_WIDTH:
					out_width_q <= cfg_data[nabd_pkg::OUT_WIDTH_W-1:0];
				nabd_pkg::CFG_OUT_HEIGHT: out_height_q <= cfg_data[HW-1:0];
				nabd_pkg::CFG_NEAREST_MODE: nearest_q <= cfg_data[0];
				nabd_pkg::CFG_NULL_VALUE: null_value_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// null value at pixel width
	logic [PW+nabd_pkg::CFG_DATA_W-1:0] null_ext;
	logic [PW-1:0]                      nul;
	assign null_ext = {{PW{1'b0}}, null_value_q};
	assign nul      = null_ext[PW-1:0];

	// effective width and height
	logic [EW-1:0] ow_ext;
	logic [EW-1:0] w_eff;
	logic [HW-1:0] h_m1;

	always_comb begin
		ow_ext = EW'(out_width_q);
		if (ow_ext == '0)
			w_eff = EW'(1);
		else if (ow_ext > MAX_W)
			w_eff = MAX_W;
		else
			w_eff = ow_ext;
		h_m1 = (out_height_q == '0) ? '0 : out_height_q - HW'(1);
	end

	// stage handshake chain
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic acc;

	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign acc      = in_valid && rdy1;

	// position of the current request
	logic [COL_W-1:0] col_q;
	logic [RW-1:0]    row_q;
	logic [COL_W-1:0] col_rs, col_cur;
	logic [RW-1:0]    row_cur;
	logic             odd, eol, last_cur;

	always_comb begin
		col_rs  = restart ? '0 : col_q;
		row_cur = restart ? '0 : row_q;
		col_cur = (EW'(col_rs) >= w_eff) ? '0 : col_rs;
		odd     = row_cur[0];
		eol     = (EW'(col_cur) == w_eff - EW'(1));
		last_cur = odd && eol && (row_cur[RW-1:1] == h_m1);
	end

	// column and line counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (last_cur) begin
				col_q <= '0;
				row_q <= '0;
			end else if (eol) begin
				col_q <= '0;
				row_q <= row_cur + RW'(1);
			end else begin
				col_q <= col_cur + COL_W'(1);
				row_q <= row_cur;
			end
		end
	end

	// upper line store: even lines write, odd lines read
	logic [2*PW-1:0] line_mem [MAX_OUT_WIDTH];
	logic [2*PW-1:0] upper_s1;
	logic [PW-1:0]   ll_s1, lr_s1;
	logic            eol_s1, last_s1;

	always_ff @(posedge clk) begin
		if (acc && !odd)
			line_mem[col_cur] <= {right_pixel, left_pixel};
		if (acc && odd)
			upper_s1 <= line_mem[col_cur];
	end

	always_ff @(posedge clk) begin
		if (acc && odd) begin
			ll_s1   <= left_pixel;
			lr_s1   <= right_pixel;
			eol_s1  <= eol;
			last_s1 <= last_cur;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= acc && odd;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// null-aware sum and count of the 2x2 block
	logic [PW-1:0] ul, ur;
	logic [SW-1:0] sum_c;
	logic [2:0]    cnt_c;

	always_comb begin
		ul    = upper_s1[PW-1:0];
		ur    = upper_s1[2*PW-1:PW];
		sum_c = '0;
		cnt_c = '0;
		if (ul != nul) begin
			sum_c = sum_c + SW'(ul);
			cnt_c = cnt_c + 3'd1;
		end
		if (ur != nul) begin
			sum_c = sum_c + SW'(ur);
			cnt_c = cnt_c + 3'd1;
		end
		if (ll_s1 != nul) begin
			sum_c = sum_c + SW'(ll_s1);
			cnt_c = cnt_c + 3'd1;
		end
		if (lr_s1 != nul) begin
			sum_c = sum_c + SW'(lr_s1);
			cnt_c = cnt_c + 3'd1;
		end
	end

	logic [SW-1:0] sum_s2;
	logic [2:0]    cnt_s2;
	logic [PW-1:0] ul_s2;
	logic          eol_s2, last_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			sum_s2  <= sum_c;
			cnt_s2  <= cnt_c;
			ul_s2   <= ul;
			eol_s2  <= eol_s1;
			last_s2 <= last_s1;
		end
	end

	// divide by three through the reciprocal
	logic [2*SW-1:0] prod_s3;
	logic [SW-1:0]   sum_s3;
	logic [2:0]      cnt_s3;
	logic [PW-1:0]   ul_s3;
	logic            eol_s3, last_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			prod_s3 <= sum_s2 * RECIP;
			sum_s3  <= sum_s2;
			cnt_s3  <= cnt_s2;
			ul_s3   <= ul_s2;
			eol_s3  <= eol_s2;
			last_s3 <= last_s2;
		end
	end

	// pick the quotient for the valid count
	logic [SW-1:0]   half, quarter;
	logic [2*SW-1:0] third;
	logic [PW-1:0]   pix_c;

	always_comb begin
		half    = sum_s3 >> 1;
		quarter = sum_s3 >> 2;
		third   = prod_s3 >> K;
		if (nearest_q) begin
			pix_c = ul_s3;
		end else begin
			case (cnt_s3)
				3'd1:    pix_c = sum_s3[PW-1:0];
				3'd2:    pix_c = half[PW-1:0];
				3'd3:    pix_c = third[PW-1:0];
				3'd4:    pix_c = quarter[PW-1:0];
				default: pix_c = nul;
			endcase
		end
	end

	// output register
	logic [PW-1:0] pix_s4;
	logic          eol_s4, last_s4;

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			pix_s4  <= pix_c;
			eol_s4  <= eol_s3;
			last_s4 <= last_s3;
		end
	end

	assign out_valid   = v_s4;
	assign out_pixel   = pix_s4;
	assign end_of_line = eol_s4;
	assign last        = last_s4;

endmodule

// ----- tb/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_W      = 256;
	localparam int unsigned PIX_W      = 16;
	localparam int unsigned SETTLE     = 8;
	localparam int unsigned MAX_CYCLE  = 300000;
	localparam int unsigned CFG_DATA_W = nabd_pkg::CFG_DATA_W;
	localparam int unsigned ROW_W      = nabd_pkg::ROW_W;

	// one decimated output pixel with its flags
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             eol;
		logic             last;
	} decimated_t;

	// predicts the decimated stream and checks what the block returns
	class decimation_scoreboard;
		logic [8:0]       width_reg;
		logic [15:0]      height_reg;
		logic             nearest_reg;
		logic [PIX_W-1:0] null_reg;
		logic [PIX_W-1:0] upper_left [MAX_W];
		logic [PIX_W-1:0] upper_right [MAX_W];
		bit               written [MAX_W];
		int unsigned      col;
		logic [ROW_W-1:0] row;
		decimated_t       pixels_due [$];
		int               errors;

		function new();
			width_reg   = nabd_pkg::OUT_WIDTH_RST;
			height_reg  = nabd_pkg::OUT_HEIGHT_RST;
			nearest_reg = 1'b0;
			null_reg    = '0;
			col         = 0;
			row         = '0;
			errors      = 0;
			foreach (written[i]) written[i] = 1'b0;
		endfunction

		function void write_reg(nabd_pkg::cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				nabd_pkg::CFG_OUT_WIDTH:    width_reg = data[8:0];
				nabd_pkg::CFG_OUT_HEIGHT:   height_reg = data;
				nabd_pkg::CFG_NEAREST_MODE: nearest_reg = data[0];
				nabd_pkg::CFG_NULL_VALUE:   null_reg = data[PIX_W-1:0];
				default: ;
			endcase
		endfunction

		// zero width acts as one, oversize saturates
		function int unsigned line_pairs();
			if (width_reg == 0) return 1;
			if (width_reg > MAX_W) return MAX_W;
			return width_reg;
		endfunction

		// true if a request without restart would read a never-written column
		function bit hits_unwritten();
			int unsigned c;
			c = col;
			if (c >= line_pairs()) c = 0;
			return row[0] && !written[c];
		endfunction

		// mean of the non-null pixels, null when none is valid
		function logic [PIX_W-1:0] box_mean(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
				logic [PIX_W-1:0] c, logic [PIX_W-1:0] d);
			logic [PIX_W-1:0] px [4];
			int unsigned sum;
			int unsigned n;
			px  = '{a, b, c, d};
			sum = 0;
			n   = 0;
			foreach (px[i]) begin
				if (px[i] != null_reg) begin
					sum += px[i];
					n++;
				end
			end
			if (n == 0) return null_reg;
			return PIX_W'(sum / n);
		endfunction

		// accepted input request: store an even line, decimate an odd one
		function void note_request(logic [PIX_W-1:0] left, logic [PIX_W-1:0] right, bit rs);
			int unsigned w;
			int unsigned h;
			int unsigned c;
			bit eol;
			bit lst;
			decimated_t res;
			w = line_pairs();
			h = (height_reg == 0) ? 1 : height_reg;
			if (rs) begin
				col = 0;
				row = '0;
			end
			if (col >= w) col = 0;
			c   = col;
			eol = (c == w - 1);
			lst = 1'b0;
			if (!row[0]) begin
				upper_left[c]  = left;
				upper_right[c] = right;
				written[c]     = 1'b1;
			end else begin
				res.pixel = nearest_reg ? upper_left[c]
					: box_mean(upper_left[c], upper_right[c], left, right);
				lst       = eol && (int'(row[ROW_W-1:1]) == h - 1);
				res.eol   = eol;
				res.last  = lst;
				pixels_due.push_back(res);
			end
			if (eol) begin
				col = 0;
				row = row + 1'b1;
			end else begin
				col = c + 1;
			end
			if (lst) begin
				col = 0;
				row = '0;
			end
		endfunction

		function void check_result(logic [PIX_W-1:0] pix, logic eol, logic lst);
			decimated_t ref_px;
			if (pixels_due.size() == 0) begin
				$error("unexpected result out_pixel=%h end_of_line=%b last=%b", pix, eol, lst);
				errors++;
				return;
			end
			ref_px = pixels_due.pop_front();
			if (pix !== ref_px.pixel) begin
				$error("out_pixel expected %h actual %h", ref_px.pixel, pix);
				errors++;
			end
			if (eol !== ref_px.eol) begin
				$error("end_of_line expected %b actual %b", ref_px.eol, eol);
				errors++;
			end
			if (lst !== ref_px.last) begin
				$error("last expected %b actual %b", ref_px.last, lst);
				errors++;
			end
		endfunction

		function int pending();
			return pixels_due.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [PIX_W-1:0]      left_pixel = '0;
	logic [PIX_W-1:0]      right_pixel = '0;
	logic                  restart = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [PIX_W-1:0]      out_pixel;
	logic                  end_of_line;
	logic                  last;
	logic                  cfg_we = 1'b0;
	nabd_pkg::cfg_index_t  cfg_index = nabd_pkg::CFG_OUT_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	decimation_scoreboard sb = new();
	int unsigned snd_idle = 0;
	int unsigned rcv_idle = 0;
	int unsigned hold_req = 0;
	int unsigned cycle_count = 0;

	null_aware_box_decimator_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.left_pixel (left_pixel),
		.right_pixel(right_pixel),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_pixel  (out_pixel),
		.end_of_line(end_of_line),
		.last       (last),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		while (cycle_count < MAX_CYCLE) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// receiver: random back-pressure, or a long hold-off when asked
	initial begin
		int unsigned hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold     = hold_req;
				hold_req = 0;
			end
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= rcv_idle);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_pixel, end_of_line, last);
	end

	task automatic write_reg(nabd_pkg::cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	// all four registers, block idle
	task automatic configure(int unsigned w, int unsigned h, bit nm, logic [PIX_W-1:0] nv);
		write_reg(nabd_pkg::CFG_OUT_WIDTH, CFG_DATA_W'(w));
		write_reg(nabd_pkg::CFG_OUT_HEIGHT, CFG_DATA_W'(h));
		write_reg(nabd_pkg::CFG_NEAREST_MODE, CFG_DATA_W'(nm));
		write_reg(nabd_pkg::CFG_NULL_VALUE, CFG_DATA_W'(nv));
		cfg_we <= 1'b0;
	endtask

	// offer one pixel-pair request and wait for it to be taken
	task automatic send_pair(logic [PIX_W-1:0] l, logic [PIX_W-1:0] r, bit rs);
		while ($urandom_range(0, 99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		if (!rs && sb.hits_unwritten()) rs = 1'b1;
		in_valid    <= 1'b1;
		left_pixel  <= l;
		right_pixel <= r;
		restart     <= rs;
		do @(posedge clk); while (!in_ready);
		sb.note_request(l, r, rs);
	endtask

	// stop sending until every result is back and the pipe is empty
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// pixel biased toward null and the range ends
	function automatic logic [PIX_W-1:0] pick_pixel();
		case ($urandom_range(0, 7))
			0, 1:    return sb.null_reg;
			2:       return '0;
			3:       return '1;
			default: return PIX_W'($urandom());
		endcase
	endfunction

	// one random setting followed by a run of requests
	task automatic run_phase(int unsigned n_items);
		int unsigned w;
		int unsigned h;
		logic [PIX_W-1:0] nv;
		case ($urandom_range(0, 9))
			0:       w = 0;
			1:       w = $urandom_range(9, 16);
			default: w = $urandom_range(1, 6);
		endcase
		case ($urandom_range(0, 7))
			0:       h = 0;
			1:       h = 16'hffff;
			default: h = $urandom_range(1, 4);
		endcase
		case ($urandom_range(0, 2))
			0:       nv = '0;
			1:       nv = '1;
			default: nv = PIX_W'($urandom());
		endcase
		configure(w, h, ($urandom_range(0, 3) == 0), nv);
		for (int i = 0; i < n_items; i++)
			send_pair(pick_pixel(), pick_pixel(),
				(i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 39) == 0));
		drain();
	endtask

	initial begin
		int unsigned n;
		int unsigned done;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_idle = 23;
		rcv_idle = 53;

		// box mode, null zero: all-null block, full-scale, partial nulls
		configure(2, 2, 1'b0, 16'h0000);
		send_pair(16'h0000, 16'h0000, 1'b1);
		send_pair(16'hffff, 16'hffff, 1'b0);
		send_pair(16'h0000, 16'h0000, 1'b0);
		send_pair(16'hffff, 16'hffff, 1'b0);
		send_pair(16'h0000, 16'h0005, 1'b0);
		send_pair(16'hffff, 16'h0000, 1'b0);
		send_pair(16'h0000, 16'h0007, 1'b0);
		send_pair(16'h0001, 16'h0002, 1'b0);
		drain();

		// null at full scale, two and four valid pixels
		configure(1, 2, 1'b0, 16'hffff);
		send_pair(16'hffff, 16'h0001, 1'b1);
		send_pair(16'h0002, 16'hffff, 1'b0);
		send_pair(16'h0003, 16'h0004, 1'b0);
		send_pair(16'h0005, 16'h0006, 1'b0);
		drain();

		// nearest mode passes null through; zero width and height act as one
		configure(0, 0, 1'b1, 16'h1234);
		send_pair(16'h1234, 16'h0007, 1'b1);
		send_pair(16'h0008, 16'h0009, 1'b0);
		send_pair(16'haaaa, 16'h5555, 1'b0);
		send_pair(16'h0001, 16'h0002, 1'b0);
		drain();

		// height lowered mid-tile: rows run past the tile with no last
		configure(1, 3, 1'b0, 16'h0000);
		send_pair(16'h0010, 16'h0020, 1'b1);
		send_pair(16'h0030, 16'h0000, 1'b0);
		send_pair(16'h8000, 16'h8000, 1'b0);
		send_pair(16'h7fff, 16'h0001, 1'b0);
		drain();
		configure(1, 1, 1'b0, 16'h0000);
		send_pair(16'h0100, 16'h0200, 1'b0);
		send_pair(16'h0300, 16'h0400, 1'b0);
		drain();

		// oversize width saturates to a full line store
		configure(511, 1, 1'($urandom_range(0, 1)), PIX_W'($urandom()));
		for (int i = 0; i < 2 * MAX_W; i++)
			send_pair(pick_pixel(), pick_pixel(), (i == 0));
		drain();

		// random tiles under three back-pressure mixes
		for (int m = 0; m < 3; m++) begin
			case (m)
				0: begin snd_idle = 23; rcv_idle = 53; end
				1: begin snd_idle = 53; rcv_idle = 23; end
				default: begin snd_idle = 0; rcv_idle = 0; end
			endcase
			done = 0;
			while (done < 50) begin
				n = $urandom_range(10, 30);
				// long receiver hold-off so the pipe fills and stalls input
				if (m == 2 && done == 0) begin
					hold_req = 200;
					n        = 40;
				end
				run_phase(n);
				done += n;
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
